// File: hw/rtl/des_pkg.sv
package des_pkg;

	localparam int NumRounds = 16;

	typedef logic [63:0] blk_t;
	typedef logic [27:0] half_t;
	typedef logic [47:0] subkey_t;

	// Round state handed from one cell to the next
	typedef struct packed {
		logic [31:0] l;
		logic [31:0] r;
		half_t       c;
		half_t       d;
	} round_t;

	// Left rotation per round: 1 or 2 places
	localparam logic [NumRounds-1:0] RotTwo = 16'b0011_1111_0111_1110;

	// Tables as published, entries 1-based with bit 1 the MSB
	localparam byte unsigned TabIp [64] = '{
		58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
		62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
		57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
		61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
	localparam byte unsigned TabFp [64] = '{
		40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
		38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
		36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
		34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
	localparam byte unsigned TabE [48] = '{
		32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
		16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};
	localparam byte unsigned TabP [32] = '{
		16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
		2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};
	localparam byte unsigned TabPc1 [56] = '{
		57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
		10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
		63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
		14,6,61,53,45,37,29, 21,13,5,28,20,12,4};
	localparam byte unsigned TabPc2 [48] = '{
		14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
		41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};
	localparam byte unsigned TabSbox [8][64] = '{
		'{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,
		  0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
		  4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,
		  15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
		'{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,
		  3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
		  0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,
		  13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
		'{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,
		  13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
		  13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,
		  1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
		'{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,
		  13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
		  10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,
		  3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
		'{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,
		  14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
		  4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,
		  11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
		'{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,
		  10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
		  9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,
		  4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
		'{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,
		  13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
		  1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,
		  6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
		'{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,
		  1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
		  7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,
		  2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

	function automatic blk_t perm_ip(input blk_t src);
		blk_t o;
		for (int i = 0; i < 64; i++) o[63-i] = src[64-int'(TabIp[i])];
		return o;
	endfunction

	function automatic blk_t perm_fp(input blk_t src);
		blk_t o;
		for (int i = 0; i < 64; i++) o[63-i] = src[64-int'(TabFp[i])];
		return o;
	endfunction

	function automatic logic [55:0] perm_pc1(input blk_t src);
		logic [55:0] o;
		for (int i = 0; i < 56; i++) o[55-i] = src[64-int'(TabPc1[i])];
		return o;
	endfunction

	function automatic subkey_t perm_pc2(input logic [55:0] src);
		subkey_t o;
		for (int i = 0; i < 48; i++) o[47-i] = src[56-int'(TabPc2[i])];
		return o;
	endfunction

	function automatic logic [47:0] perm_e(input logic [31:0] src);
		logic [47:0] o;
		for (int i = 0; i < 48; i++) o[47-i] = src[32-int'(TabE[i])];
		return o;
	endfunction

	function automatic logic [31:0] perm_p(input logic [31:0] src);
		logic [31:0] o;
		for (int i = 0; i < 32; i++) o[31-i] = src[32-int'(TabP[i])];
		return o;
	endfunction

endpackage

// File: hw/rtl/des_round_cell.sv
module des_round_cell #(
	parameter logic ROT_TWO = 1'b0
) (
	input  logic             clk,
	input  logic             en,
	input  des_pkg::round_t  rnd_in,
	output des_pkg::round_t  rnd_s1
);
	import des_pkg::*;

	half_t       c_rot;
	half_t       d_rot;
	subkey_t     sk;
	logic [47:0] x;
	logic [31:0] sout;
	logic [5:0]  six;

	// Rotate key halves and form the round function
	always_comb begin
		if (ROT_TWO) begin
			c_rot = {rnd_in.c[25:0], rnd_in.c[27:26]};
			d_rot = {rnd_in.d[25:0], rnd_in.d[27:26]};
		end else begin
			c_rot = {rnd_in.c[26:0], rnd_in.c[27]};
			d_rot = {rnd_in.d[26:0], rnd_in.d[27]};
		end
		sk = perm_pc2({c_rot, d_rot});
		x  = perm_e(rnd_in.r) ^ sk;
		sout = '0;
		for (int b = 0; b < 8; b++) begin
			six = x[47-6*b -: 6];
			sout[31-4*b -: 4] = TabSbox[b][{six[5], six[0], six[4:1]}][3:0];
		end
	end

	// Advance the word one round
	always_ff @(posedge clk) begin
		if (en) begin
			rnd_s1.l <= rnd_in.r;
			rnd_s1.r <= rnd_in.l ^ perm_p(sout);
			rnd_s1.c <= c_rot;
			rnd_s1.d <= d_rot;
		end
	end
endmodule

// File: hw/rtl/des_block_encrypt_core.sv
// Channel | Dir | Fields (tdata, low bit up)
// s_axis  | in  | plaintext[63:0], cipher_key[127:64]
// m_axis  | out | ciphertext[63:0]
// One word per cycle sustained while the output is not stalled; the chain is an input register
// holding IP/PC-1, sixteen round cells, and an output register after FP.
// The chain advances as one whole; it stalls only when the output register
// holds a word and m_axis_tready is low. Reset clears valid bits only.
module des_block_encrypt_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,  // plaintext[63:0], cipher_key[127:64]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [63:0]  m_axis_tdata   // ciphertext[63:0]
);
	import des_pkg::*;

	localparam int Stages = NumRounds + 1;

	logic              adv;
	logic [Stages-1:0] vld_q;
	round_t            chain [NumRounds+1];
	blk_t              ip_blk;
	logic [55:0]       k56;
	logic [63:0]       ct_q;
	logic              ct_vld_q;

	// Move whole chain whenever the output register is free
	assign adv           = !ct_vld_q || m_axis_tready;
	assign s_axis_tready = adv;

	assign ip_blk = perm_ip(s_axis_tdata[63:0]);
	assign k56    = perm_pc1(s_axis_tdata[127:64]);

	// Hold initial permuted word
	always_ff @(posedge clk) begin
		if (adv) begin
			chain[0] <= '{l: ip_blk[63:32], r: ip_blk[31:0], c: k56[55:28], d: k56[27:0]};
		end
	end

	for (genvar g = 0; g < NumRounds; g++) begin : g_round
		des_round_cell #(.ROT_TWO(RotTwo[NumRounds-1-g])) u_cell (
			.clk    (clk),
			.en     (adv),
			.rnd_in (chain[g]),
			.rnd_s1 (chain[g+1])
		);
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			ct_vld_q <= 1'b0;
		end else if (adv) begin
			vld_q    <= {vld_q[Stages-2:0], s_axis_tvalid};
			ct_vld_q <= vld_q[Stages-1];
		end
	end

	// Apply final permutation into output register
	always_ff @(posedge clk) begin
		if (adv) begin
			ct_q <= perm_fp({chain[NumRounds].r, chain[NumRounds].l});
		end
	end

	assign m_axis_tvalid = ct_vld_q;
	assign m_axis_tdata  = ct_q;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_q))
		else $error("valid bits moved during stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("ready not tied to output state");
	a_out_from_chain: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> m_axis_tvalid == $past(vld_q[Stages-1]))
		else $error("output valid lost");
endmodule

// File: tb/sv/des_block_encrypt_core_tb.sv
`timescale 1ns / 1ps

module des_block_encrypt_core_tb;
	import des_pkg::*;

	localparam int RandomBlocks = 830;
	localparam int Latency = 18;
	localparam longint CycleLimit = 400000;

	// Expected ciphertexts in order of acceptance
	class cipher_scoreboard;
		blk_t pending[$];
		int mismatches;
		int reported;

		function new();
			mismatches = 0;
			reported = 0;
		endfunction

		// Encrypt the block under the key and hold the ciphertext
		function void note_block(blk_t plain, blk_t key);
			blk_t blk;
			blk_t pre;
			logic [55:0] k56;
			logic [55:0] cd;
			logic [31:0] lh, rh, fout, tmp;
			half_t ch, dh;
			subkey_t sk;
			logic [47:0] x;
			logic [5:0] six;
			logic [31:0] sout;
			int sh, rw, cl;
			blk = '0;
			for (int i = 0; i < 64; i++) blk[63-i] = plain[64-int'(TabIp[i])];
			k56 = '0;
			for (int i = 0; i < 56; i++) k56[55-i] = key[64-int'(TabPc1[i])];
			lh = blk[63:32];
			rh = blk[31:0];
			ch = k56[55:28];
			dh = k56[27:0];
			for (int rnd = 0; rnd < NumRounds; rnd++) begin
				sh = RotTwo[NumRounds-1-rnd] ? 2 : 1;
				ch = (ch << sh) | (ch >> (28 - sh));
				dh = (dh << sh) | (dh >> (28 - sh));
				cd = {ch, dh};
				for (int i = 0; i < 48; i++)
					sk[47-i] = cd[56-int'(TabPc2[i])];
				for (int i = 0; i < 48; i++) x[47-i] = rh[32-int'(TabE[i])];
				x = x ^ sk;
				sout = '0;
				for (int b = 0; b < 8; b++) begin
					six = x[47-6*b -: 6];
					rw = {six[5], six[0]};
					cl = six[4:1];
					sout = (sout << 4) | 32'(TabSbox[b][rw*16+cl]);
				end
				for (int i = 0; i < 32; i++) fout[31-i] = sout[32-int'(TabP[i])];
				tmp = lh ^ fout;
				lh = rh;
				rh = tmp;
			end
			pre = {rh, lh};
			for (int i = 0; i < 64; i++) blk[63-i] = pre[64-int'(TabFp[i])];
			pending.push_back(blk);
		endfunction

		function void check_cipher(blk_t got);
			blk_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (reported < 10) begin
					reported++;
					$display("unexpected ciphertext %h", got);
				end
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				mismatches++;
				if (reported < 10) begin
					reported++;
					$display("ciphertext mismatch: expected %h, got %h", want, got);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [127:0] s_axis_tdata;  // plaintext[63:0], cipher_key[127:64]
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [63:0] m_axis_tdata;   // ciphertext[63:0]

	cipher_scoreboard sb;
	bit calm;
	longint cycles;

	des_block_encrypt_core uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Check words on the output and bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && m_axis_tvalid && m_axis_tready) sb.check_cipher(m_axis_tdata);
		if (arst_n && s_axis_tvalid && s_axis_tready)
			sb.note_block(s_axis_tdata[63:0], s_axis_tdata[127:64]);
		if (cycles > CycleLimit) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Stall the receiver in random bursts
	initial begin
		int gap;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 7) == 0) begin
				gap = $urandom_range(1, 17);
				m_axis_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	// Offer one word and hold it until taken
	task automatic send_block(blk_t plain, blk_t key);
		int gap;
		if (!calm && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 17);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {key, plain};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic blk_t rand_word();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return blk_t'(1) << $urandom_range(0, 63);
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	initial begin
		int wait_cycles;
		sb = new();
		calm = 1'b0;
		cycles = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: textbook vector, extremes, weak and semi-weak keys, parity
		send_block(64'h0123456789ABCDEF, 64'h133457799BBCDFF1);
		send_block(64'h0, 64'h0);
		send_block(64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF);
		send_block(64'h0, 64'hFFFFFFFFFFFFFFFF);
		send_block(64'hFFFFFFFFFFFFFFFF, 64'h0);
		send_block(64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA);
		send_block(64'h0123456789ABCDEF, 64'h0101010101010101);
		send_block(64'h0123456789ABCDEF, 64'hFEFEFEFEFEFEFEFE);
		send_block(64'h0123456789ABCDEF, 64'h1F1F1F1F0E0E0E0E);
		send_block(64'h0123456789ABCDEF, 64'h01FE01FE01FE01FE);
		send_block(64'h0123456789ABCDEF, 64'h133457799BBCDFF1 ^ 64'h0101010101010101);
		send_block(64'h8000000000000000, 64'h0000000000000001);
		send_block(64'h0000000000000001, 64'h8000000000000000);
		for (int i = 0; i < 7; i++)
			send_block(64'h1 << (9 * i), 64'h80 << (8 * i));

		for (int i = 0; i < RandomBlocks; i++) begin
			if (i == RandomBlocks - 120) calm = 1'b1;
			send_block(rand_word(), rand_word());
		end
		s_axis_tvalid <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		wait_cycles = 0;
		while (wait_cycles < Latency + 4) begin
			@(posedge clk);
			wait_cycles++;
		end
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// File: des_block_encrypt_core.f
hw/rtl/des_pkg.sv
hw/rtl/des_round_cell.sv
hw/rtl/des_block_encrypt_core.sv
tb/sv/des_block_encrypt_core_tb.sv
